FILE: rtl/core/ces_pkg.sv
// Shared widths, codes and controller/datapath interface types for the exon scorer.
`default_nettype none

package ces_pkg;

	localparam int COORD_BITS    = 32;
	localparam int IDENT_BITS    = 17;
	localparam int FRAC_BITS     = 16;
	localparam int LEN_BITS      = 32;
	localparam int CFG_BITS      = 16;
	localparam int SUM_BITS      = 56;
	localparam int PROD_BITS     = LEN_BITS + IDENT_BITS;
	localparam int TALLY_BITS    = 16;
	localparam int MC_BITS       = 32;
	localparam int BIN_BITS      = 8;
	localparam int NUM_BITS      = MC_BITS + 4;
	localparam int DEN_BITS      = LEN_BITS + BIN_BITS;
	localparam int QBIT_BITS     = $clog2(BIN_BITS);

	localparam int IN_DATA_BITS  = 216;
	localparam int OUT_DATA_BITS = 64;

	localparam int APB_ADDR_BITS = 3;
	localparam int APB_DATA_BITS = 32;

	localparam logic REG_MIN_EXON   = 1'b0;
	localparam logic REG_MIN_INTRON = 1'b1;

	localparam logic [CFG_BITS-1:0] MIN_EXON_RESET   = 16'd10;
	localparam logic [CFG_BITS-1:0] MIN_INTRON_RESET = 16'd25;

	// datapath commands, one per controller state
	typedef struct packed {
		logic load;
		logic eval1;
		logic eval2;
		logic accum;
		logic round;
		logic scale;
		logic check;
		logic step;
		logic emit;
	} ces_cmd_t;

	typedef struct packed {
		logic last;
		logic sat;
		logic div_done;
	} ces_sts_t;

endpackage

`default_nettype wire

FILE: rtl/core/compartment_exon_scorer.sv
// A non-final hit passes through capture, two evaluate steps and accumulate, then frees the block.
// A final hit then goes through round, scale and check and, when not saturated, the 8-step
// restoring divider for the identity bin before emit; a saturated bin skips the divider.
// A new hit is taken only when idle; the result register frees the input while a result waits.
// Reset (arst_n low): compartment state cleared, min_exon_length 10, min_intron_length 25.
`default_nettype none

module compartment_exon_scorer import ces_pkg::*; (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	// slave side
	input  wire logic                     s_tvalid,
	output logic                          s_tready,
	// query_start, query_stop, subj_start, subj_stop, subj_strand, identity,
	// hit_length, query_length, zero fill
	input  wire logic [IN_DATA_BITS-1:0]  s_tdata,
	input  wire logic                     s_tlast,
	// master side
	output logic                          m_tvalid,
	input  wire logic                     m_tready,
	// exon_count, match_count, identity_bin, strand_error, zero fill
	output logic      [OUT_DATA_BITS-1:0] m_tdata,
	// configuration
	input  wire logic                     psel,
	input  wire logic                     penable,
	input  wire logic                     pwrite,
	input  wire logic [APB_ADDR_BITS-1:0] paddr,
	input  wire logic [APB_DATA_BITS-1:0] pwdata,
	output logic      [APB_DATA_BITS-1:0] prdata,
	output logic                          pready
);

	logic [CFG_BITS-1:0] min_exon_q;
	logic [CFG_BITS-1:0] min_intron_q;
	logic                wr_en;
	ces_cmd_t            cmd;
	ces_sts_t            sts;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_exon_q   <= MIN_EXON_RESET;
			min_intron_q <= MIN_INTRON_RESET;
		end else if (wr_en) begin
			if (paddr[2] == REG_MIN_INTRON) begin
				min_intron_q <= pwdata[CFG_BITS-1:0];
			end else begin
				min_exon_q <= pwdata[CFG_BITS-1:0];
			end
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[1:0] == 2'b00) begin
			if (paddr[2] == REG_MIN_EXON) begin
				prdata = APB_DATA_BITS'(min_exon_q);
			end else begin
				prdata = APB_DATA_BITS'(min_intron_q);
			end
		end
	end

	ces_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	ces_dp u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.sts               (sts),
		.s_tdata           (s_tdata),
		.s_tlast           (s_tlast),
		.min_exon_length   (min_exon_q),
		.min_intron_length (min_intron_q),
		.m_tdata           (m_tdata)
	);

endmodule

`default_nettype wire

FILE: rtl/core/ces_ctrl.sv
// Sequencing controller: steps one hit through evaluation and accumulation, and the final hit through scoring.
`default_nettype none

module ces_ctrl import ces_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     s_tvalid,
	output logic          s_tready,
	output logic          m_tvalid,
	input  wire logic     m_tready,
	input  wire ces_sts_t sts,
	output ces_cmd_t      cmd
);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_EV1   = 4'd1;
	localparam logic [3:0] ST_EV2   = 4'd2;
	localparam logic [3:0] ST_ACC   = 4'd3;
	localparam logic [3:0] ST_ROUND = 4'd4;
	localparam logic [3:0] ST_SCALE = 4'd5;
	localparam logic [3:0] ST_CHECK = 4'd6;
	localparam logic [3:0] ST_DIV   = 4'd7;
	localparam logic [3:0] ST_EMIT  = 4'd8;

	logic [3:0] state_q;
	logic [3:0] state_d;
	logic       out_valid_q;
	logic       out_free;

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;
	assign out_free = !out_valid_q || m_tready;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = ST_EV1;
				end
			end
			ST_EV1: begin
				cmd.eval1 = 1'b1;
				state_d   = ST_EV2;
			end
			ST_EV2: begin
				cmd.eval2 = 1'b1;
				state_d   = ST_ACC;
			end
			ST_ACC: begin
				cmd.accum = 1'b1;
				state_d   = sts.last ? ST_ROUND : ST_IDLE;
			end
			ST_ROUND: begin
				cmd.round = 1'b1;
				state_d   = ST_SCALE;
			end
			ST_SCALE: begin
				cmd.scale = 1'b1;
				state_d   = ST_CHECK;
			end
			ST_CHECK: begin
				cmd.check = 1'b1;
				state_d   = sts.sat ? ST_EMIT : ST_DIV;
			end
			ST_DIV: begin
				cmd.step = 1'b1;
				if (sts.div_done) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				// hold until the output register is free
				if (out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/ces_dp.sv
// Datapath: hit registers, compartment state, match multiplier, rounding and bin divider.
`default_nettype none

module ces_dp import ces_pkg::*; (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire ces_cmd_t                 cmd,
	output ces_sts_t                      sts,
	input  wire logic [IN_DATA_BITS-1:0]  s_tdata,
	input  wire logic                     s_tlast,
	input  wire logic [CFG_BITS-1:0]      min_exon_length,
	input  wire logic [CFG_BITS-1:0]      min_intron_length,
	output logic      [OUT_DATA_BITS-1:0] m_tdata
);

	localparam logic [1:0] ACC_HOLD = 2'd0;
	localparam logic [1:0] ACC_LOAD = 2'd1;
	localparam logic [1:0] ACC_ADD  = 2'd2;

	// hit registers
	logic [COORD_BITS-1:0] qstart_q, qstop_q, sstart_q, sstop_q;
	logic                  strand_q;
	logic [IDENT_BITS-1:0] idty_q;
	logic [LEN_BITS-1:0]   hlen_q, qlen_q;
	logic                  last_q;

	// compartment state
	logic                  expect_first_q;
	logic                  comp_strand_q;
	logic [COORD_BITS-1:0] prev_qstop_q, prev_sstop_q;
	logic [TALLY_BITS-1:0] tally_q;
	logic [SUM_BITS-1:0]   sum_q;
	logic                  fault_q;

	// evaluation stage
	logic                  mism_q, reach_q;
	logic [COORD_BITS-1:0] s0_q, delta_q;
	logic [PROD_BITS-1:0]  prod_q;
	logic [1:0]            acc_op_q;

	// scoring
	logic [MC_BITS-1:0]    mc_q;
	logic [NUM_BITS-1:0]   rem_q;
	logic [BIN_BITS-1:0]   quo_q;
	logic [QBIT_BITS-1:0]  bit_q;
	logic                  sat_q;

	// output register
	logic [TALLY_BITS-1:0] exon_out_q;
	logic [MC_BITS-1:0]    mc_out_q;
	logic [BIN_BITS-1:0]   bin_out_q;
	logic                  serr_out_q;

	logic [COORD_BITS-1:0] q0max, offset, s0, qadv;
	logic                  reach;
	logic [COORD_BITS-1:0] gap_lo, gap_hi;
	logic                  new_exon;
	logic [LEN_BITS-1:0]   mul_a;
	logic [SUM_BITS:0]     sum_ext;
	logic [SUM_BITS:0]     rnd;
	logic [DEN_BITS-1:0]   den_full, trial;
	logic                  sat;

	assign q0max  = (prev_qstop_q > qstart_q) ? prev_qstop_q : qstart_q;
	assign offset = qstart_q - prev_qstop_q;
	assign s0     = comp_strand_q ? (sstart_q - offset) : (sstart_q + offset);
	assign qadv   = qstop_q - prev_qstop_q;
	assign reach  = (qstop_q >= prev_qstop_q)
		&& (qadv >= COORD_BITS'(min_exon_length));

	// plus strand looks forward from the previous stop, minus strand backward
	assign gap_lo   = comp_strand_q ? prev_sstop_q : s0_q;
	assign gap_hi   = comp_strand_q ? s0_q : prev_sstop_q;
	assign new_exon = (gap_hi >= gap_lo)
		&& ((gap_hi - gap_lo) >= COORD_BITS'(min_intron_length));

	assign mul_a   = expect_first_q ? hlen_q : delta_q;
	assign sum_ext = {1'b0, sum_q} + (SUM_BITS+1)'(prod_q);
	assign rnd     = {1'b0, sum_q} + (SUM_BITS+1)'(1 << (FRAC_BITS - 1));

	assign den_full = {qlen_q, {BIN_BITS{1'b0}}};
	assign trial    = DEN_BITS'(qlen_q) << bit_q;
	assign sat      = (qlen_q == '0) || (DEN_BITS'(rem_q) >= den_full);

	assign sts.last     = last_q;
	assign sts.sat      = sat;
	assign sts.div_done = (bit_q == '0);

	assign m_tdata = OUT_DATA_BITS'({serr_out_q, bin_out_q, mc_out_q, exon_out_q});

	// hit capture, evaluation, scoring and output registers, no reset needed
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			qstart_q <= s_tdata[31:0];
			qstop_q  <= s_tdata[63:32];
			sstart_q <= s_tdata[95:64];
			sstop_q  <= s_tdata[127:96];
			strand_q <= s_tdata[128];
			idty_q   <= s_tdata[145:129];
			hlen_q   <= s_tdata[177:146];
			qlen_q   <= s_tdata[209:178];
			last_q   <= s_tlast;
		end
		if (cmd.eval1) begin
			mism_q  <= !expect_first_q && (strand_q != comp_strand_q);
			reach_q <= reach;
			s0_q    <= s0;
			delta_q <= qstop_q - q0max;
		end
		if (cmd.eval2) begin
			prod_q <= PROD_BITS'(mul_a) * PROD_BITS'(idty_q);
		end
		if (cmd.round) begin
			if (rnd[SUM_BITS:FRAC_BITS+MC_BITS] != '0) begin
				mc_q <= '1;
			end else begin
				mc_q <= rnd[FRAC_BITS+MC_BITS-1:FRAC_BITS];
			end
		end
		if (cmd.scale) begin
			// times ten as eight plus two
			rem_q <= (NUM_BITS'(mc_q) << 3) + (NUM_BITS'(mc_q) << 1);
		end
		if (cmd.check) begin
			sat_q <= sat;
			quo_q <= '0;
			bit_q <= QBIT_BITS'(BIN_BITS - 1);
		end
		if (cmd.step) begin
			if (DEN_BITS'(rem_q) >= trial) begin
				rem_q        <= rem_q - trial[NUM_BITS-1:0];
				quo_q[bit_q] <= 1'b1;
			end
			bit_q <= bit_q - 1'b1;
		end
		if (cmd.emit) begin
			exon_out_q <= tally_q;
			mc_out_q   <= mc_q;
			bin_out_q  <= sat_q ? '1 : quo_q;
			serr_out_q <= fault_q;
		end
	end

	// compartment state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expect_first_q <= 1'b1;
			comp_strand_q  <= 1'b0;
			prev_qstop_q   <= '0;
			prev_sstop_q   <= '0;
			tally_q        <= TALLY_BITS'(1);
			sum_q          <= '0;
			fault_q        <= 1'b0;
			acc_op_q       <= ACC_HOLD;
		end else if (cmd.emit) begin
			expect_first_q <= 1'b1;
			comp_strand_q  <= 1'b0;
			prev_qstop_q   <= '0;
			prev_sstop_q   <= '0;
			tally_q        <= TALLY_BITS'(1);
			sum_q          <= '0;
			fault_q        <= 1'b0;
			acc_op_q       <= ACC_HOLD;
		end else begin
			if (cmd.eval2) begin
				acc_op_q <= ACC_HOLD;
				if (expect_first_q) begin
					expect_first_q <= 1'b0;
					comp_strand_q  <= strand_q;
					tally_q        <= TALLY_BITS'(1);
					prev_qstop_q   <= qstop_q;
					prev_sstop_q   <= sstop_q;
					acc_op_q       <= ACC_LOAD;
				end else if (mism_q) begin
					// drop the hit, keep the previous one as reference
					fault_q <= 1'b1;
				end else begin
					if (reach_q) begin
						if (new_exon && (tally_q != '1)) begin
							tally_q <= tally_q + 1'b1;
						end
						acc_op_q <= ACC_ADD;
					end
					prev_qstop_q <= qstop_q;
					prev_sstop_q <= sstop_q;
				end
			end
			if (cmd.accum) begin
				case (acc_op_q)
					ACC_LOAD: sum_q <= SUM_BITS'(prod_q);
					ACC_ADD:  sum_q <= sum_ext[SUM_BITS] ? '1 : sum_ext[SUM_BITS-1:0];
					default:  sum_q <= sum_q;
				endcase
			end
		end
	end

endmodule

`default_nettype wire
